// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Same-cycle and next-cycle implication checks. Defining NO_ASSERTIONS
// compiles them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, codes and control structs of the servo triangle sweep.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int POS_W     = 12;
   localparam int OFFSET_W  = 12;
   localparam int CMD_W     = 2;
   localparam int DUR_W     = 16;
   localparam int ELAPSED_W = 17;
   localparam int PROD_W    = POS_W + DUR_W;   // |diff| * phase time, both as magnitudes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = DUR_W;

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RETURN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NEUTRAL  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 1'd1;

   localparam logic [POS_W-1:0]     NEUTRAL_RESET  = 12'd1500;
   localparam logic [DUR_W-1:0]     DURATION_RESET = 16'd1000;
   localparam logic [POS_W-1:0]     POS_RESET      = 12'd1500;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = '1;

   // controller -> datapath
   typedef struct packed {
      logic start_sweep;   // arm a sweep from neutral
      logic stop;          // write neutral, end sweep
      logic advance;       // elapsed += 1, saturating
      logic load_mul;      // register |diff| * phase time
      logic div_start;     // launch serial divide by duration
      logic write_interp;  // write interpolated position
      logic capture;       // load response word
      logic drive;         // drive bit of the response word
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sweeping;
      logic phase_rise;    // elapsed < duration
      logic phase_fall;    // elapsed < 2 * duration
      logic div_done;
   } dp_status_type;

endpackage

// ===== hdl/sts_if.sv =====
// ----------------------------------------------------------------------------
// sts_req_if / sts_rsp_if
// Valid/ready channels of the servo triangle sweep.
// ----------------------------------------------------------------------------
interface sts_req_if
   import sts_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           cmd;
   logic signed [OFFSET_W-1:0] offset_us;

   modport source (output valid, output cmd, output offset_us, input ready);
   modport sink   (input valid, input cmd, input offset_us, output ready);
endinterface

interface sts_rsp_if
   import sts_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position_us;
   logic             drive;
   logic             busy_res;

   modport source (output valid, output position_us, output drive, output busy_res,
                   input ready);
   modport sink   (input valid, input position_us, input drive, input busy_res,
                   output ready);
endinterface

// ===== hdl/sts_div.sv =====
// ----------------------------------------------------------------------------
// sts_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module sts_div
   import sts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [DUR_W-1:0]  divisor,
   output logic [POS_W-1:0]  quotient,
   output logic              done
);

   localparam int CNT_W = $clog2(PROD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

   logic [DUR_W-1:0]  rem_ff;
   logic [PROD_W-1:0] quo_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DUR_W:0] trial;
   logic [DUR_W:0] trial_sub;
   logic           fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[PROD_W-1]};
      fits      = (trial >= {1'b0, divisor});
      trial_sub = trial - {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            rem_ff   <= '0;
            quo_ff   <= dividend;
         end else if (busy_ff) begin
            // remainder stays below divisor, so 16 bits hold it
            rem_ff <= fits ? trial_sub[DUR_W-1:0] : trial[DUR_W-1:0];
            quo_ff <= {quo_ff[PROD_W-2:0], fits};
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

   // quotient <= |diff| <= 4095
   assign quotient = quo_ff[POS_W-1:0];
   assign done     = done_ff;

endmodule

// ===== hdl/sts_datapath.sv =====
// ----------------------------------------------------------------------------
// sts_datapath
// Sweep state, config registers, multiplier, divider and response word.
// ----------------------------------------------------------------------------
module sts_datapath
   import sts_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic signed [OFFSET_W-1:0] req_offset_us,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   output logic [POS_W-1:0]           rsp_position_us,
   output logic                       rsp_drive,
   output logic                       rsp_busy_res
);

   logic [POS_W-1:0]     neutral_ff;
   logic [DUR_W-1:0]     duration_ff;
   logic                 sweeping_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [POS_W-1:0]     target_ff;
   logic [POS_W-1:0]     start_ff;
   logic [POS_W-1:0]     current_ff;

   logic [PROD_W-1:0]    prod_ff;
   logic                 neg_ff;
   logic                 rise_ff;

   logic [POS_W-1:0]     pos_out_ff;
   logic                 drive_out_ff;
   logic                 busy_out_ff;

   logic [POS_W:0]       diff;
   logic [POS_W-1:0]     diff_mag;
   logic [ELAPSED_W-1:0] fall_time;
   logic [DUR_W-1:0]     mul_time;
   logic                 phase_rise;
   logic                 phase_fall;
   logic [POS_W+1:0]     target_sum;
   logic [POS_W+1:0]     interp_sum;
   logic [POS_W-1:0]     base_pos;
   logic [POS_W-1:0]     quotient;
   logic                 div_done;
   logic                 subtract;

   function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W+1:0] v);
      logic [POS_W-1:0] r;
      if (v[POS_W+1])
         r = '0;
      else if (v[POS_W])
         r = '1;
      else
         r = v[POS_W-1:0];
      return r;
   endfunction

   always_comb begin
      phase_rise = (elapsed_ff < {1'b0, duration_ff});
      phase_fall = (elapsed_ff < {duration_ff, 1'b0});
      diff       = {1'b0, target_ff} - {1'b0, start_ff};
      diff_mag   = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
      fall_time  = elapsed_ff - {1'b0, duration_ff};
      // both phases keep the time below duration, so 16 bits suffice
      mul_time   = phase_rise ? elapsed_ff[DUR_W-1:0] : fall_time[DUR_W-1:0];
      target_sum = {2'b00, neutral_ff} + {{2{req_offset_us[OFFSET_W-1]}}, req_offset_us};
      base_pos   = rise_ff ? start_ff : target_ff;
      // rise adds the signed step, fall takes it away
      subtract   = neg_ff ^ ~rise_ff;
      interp_sum = subtract ? ({2'b00, base_pos} - {2'b00, quotient})
                            : ({2'b00, base_pos} + {2'b00, quotient});
   end

   sts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (duration_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_ff  <= NEUTRAL_RESET;
         duration_ff <= DURATION_RESET;
         sweeping_ff <= 1'b0;
         elapsed_ff  <= '0;
         target_ff   <= POS_RESET;
         start_ff    <= POS_RESET;
         current_ff  <= POS_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NEUTRAL:  neutral_ff  <= csr_wdata[POS_W-1:0];
               CSR_DURATION: duration_ff <= csr_wdata[DUR_W-1:0];
               default: ;
            endcase
         end
         if (cmd.start_sweep) begin
            start_ff    <= neutral_ff;
            target_ff   <= clamp_pos(target_sum);
            elapsed_ff  <= '0;
            sweeping_ff <= 1'b1;
         end
         if (cmd.advance && (elapsed_ff != ELAPSED_MAX))
            elapsed_ff <= elapsed_ff + 1'b1;
         if (cmd.stop) begin
            sweeping_ff <= 1'b0;
            current_ff  <= neutral_ff;
         end
         if (cmd.write_interp)
            current_ff <= clamp_pos(interp_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_mul) begin
         prod_ff <= PROD_W'(diff_mag * mul_time);
         neg_ff  <= diff[POS_W];
         rise_ff <= phase_rise;
      end
      if (cmd.capture) begin
         pos_out_ff   <= current_ff;
         drive_out_ff <= cmd.drive;
         busy_out_ff  <= sweeping_ff;
      end
   end

   assign status.sweeping   = sweeping_ff;
   assign status.phase_rise = phase_rise;
   assign status.phase_fall = phase_fall;
   assign status.div_done   = div_done;

   assign rsp_position_us = pos_out_ff;
   assign rsp_drive       = drive_out_ff;
   assign rsp_busy_res    = busy_out_ff;

endmodule

// ===== hdl/sts_ctrl.sv =====
// ----------------------------------------------------------------------------
// sts_ctrl
// Sequencer: decodes each word, steps the datapath, owns response valid.
// ----------------------------------------------------------------------------
module sts_ctrl
   import sts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  dp_status_type    status,
   output dp_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PHASE,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      drive_ff, drive_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   always_comb begin
      accept       = req_valid && (state_ff == ST_IDLE);
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      drive_in     = drive_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.drive    = drive_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               drive_in = 1'b0;
               state_in = ST_FINISH;
               case (req_cmd)
                  CMD_TICK: begin
                     if (status.sweeping) begin
                        cmd.advance = 1'b1;
                        state_in    = ST_PHASE;
                     end
                  end
                  CMD_START: begin
                     if (!status.sweeping)
                        cmd.start_sweep = 1'b1;
                  end
                  CMD_RETURN: begin
                     cmd.stop = 1'b1;
                     drive_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_PHASE: begin
            drive_in = 1'b1;
            if (status.phase_rise || status.phase_fall) begin
               cmd.load_mul = 1'b1;
               state_in     = ST_LOAD;
            end else begin
               // past twice the duration (or zero duration): park at neutral
               cmd.stop = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.write_interp = 1'b1;
               state_in         = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drive_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drive_ff     <= drive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/servo_triangle_sweep.sv =====
// ----------------------------------------------------------------------------
// servo_triangle_sweep
// Triangle sweep of a servo pulse width: neutral -> neutral+offset -> neutral.
//
//   channel   dir   handshake        word
//   req_ch    in    valid/ready      cmd, offset_us
//   rsp_ch    out   valid/ready      position_us, drive, busy_res
//   csr_*     in    csr_we only      csr_index, csr_wdata
//
// One word is worked on at a time. A tick inside the sweep passes the phase check,
// multiplier load and serial divider (one quotient bit a cycle) before raising
// its response; ticks that end the sweep and other words skip the divider; the
// next word is taken the cycle after the response is loaded. A new word is taken
// while the last response still waits; its own response holds until the output
// register frees. Synchronous active-high reset restores the power-on config.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module servo_triangle_sweep
   import sts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sts_req_if.sink               req_ch,
   sts_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          take_return;
   logic          take_start;

   sts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   sts_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_offset_us   (req_ch.offset_us),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .rsp_position_us (rsp_ch.position_us),
      .rsp_drive       (rsp_ch.drive),
      .rsp_busy_res    (rsp_ch.busy_res)
   );

   assign take_return = req_ch.valid && req_ch.ready && (req_ch.cmd == CMD_RETURN);
   assign take_start  = req_ch.valid && req_ch.ready && (req_ch.cmd == CMD_START);

   `ASSERT_IMPLIES(a_interp_after_div, clock, reset, dp_cmd.write_interp, dp_status.div_done)
   `ASSERT_NEXT(a_return_stops, clock, reset, take_return, !dp_status.sweeping)
   `ASSERT_NEXT(a_start_arms, clock, reset, take_start, dp_status.sweeping)
   `ASSERT_IMPLIES(a_mul_in_sweep, clock, reset, dp_cmd.load_mul, dp_status.sweeping)

endmodule

// ===== verif/tb_servo_triangle_sweep.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_triangle_sweep
// Self-checking bench for the servo triangle sweep. A queue-fed driver offers
// tick, start, return and unused-code words. Each accepted word is run through
// a local sweep predictor, and the monitor compares every response word with
// the oldest prediction. Registers change only while no word is in flight.
// Idle and stall rates vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_servo_triangle_sweep;
   import sts_pkg::*;

   localparam logic [CMD_W-1:0]           CMD_UNUSED = 2'd3;
   localparam logic signed [OFFSET_W-1:0] OFS_MIN    = -12'sd2048;
   localparam logic signed [OFFSET_W-1:0] OFS_MAX    = 12'sd2047;
   localparam logic [POS_W-1:0]           POS_TOP    = '1;
   localparam int RANDOM_WORDS  = 1950;
   localparam int PHASE_WORDS   = 70;
   localparam int HOLDOFF_TICKS = 400;
   localparam int PRINT_CAP     = 40;

   typedef struct {
      logic [CMD_W-1:0]           cmd;
      logic signed [OFFSET_W-1:0] offset;
      bit                         hold;    // wait for all responses before offering
   } servo_req_type;

   typedef struct {
      logic [POS_W-1:0] pos;
      logic             drive;
      logic             busy;
   } servo_word_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sts_req_if req_if ();
   sts_rsp_if rsp_if ();

   servo_triangle_sweep dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   servo_req_type  req_words[$];
   servo_word_type owed_words[$];

   // predictor state and register copies
   logic [POS_W-1:0]     p_neutral;
   logic [DUR_W-1:0]     p_duration;
   logic                 p_sweeping;
   logic [ELAPSED_W-1:0] p_elapsed;
   logic [POS_W-1:0]     p_target;
   logic [POS_W-1:0]     p_start;
   logic [POS_W-1:0]     p_current;

   int sender_idle_pct;
   int sink_stall_pct;
   int errors;
   int sweep_words_made;
   bit holdoff_go;
   logic holdoff_active;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [POS_W-1:0] clamp_pos(longint v);
      if (v < 0) return '0;
      if (v > longint'(POS_TOP)) return POS_TOP;
      return v[POS_W-1:0];
   endfunction

   function automatic servo_word_type advance_servo(logic [CMD_W-1:0] cmd,
                                                    logic signed [OFFSET_W-1:0] ofs);
      servo_word_type w;
      longint span;
      longint e;
      longint d;
      w.drive = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (p_sweeping) begin
               d    = longint'(p_duration);
               span = longint'(p_target) - longint'(p_start);
               if (p_elapsed != ELAPSED_MAX) p_elapsed = p_elapsed + 1'b1;
               e = longint'(p_elapsed);
               // zero duration fails both phase tests, so no divide happens
               if (e < d) begin
                  p_current = clamp_pos(longint'(p_start) + span * e / d);
               end else if (e < 2 * d) begin
                  p_current = clamp_pos(longint'(p_target) - span * (e - d) / d);
               end else begin
                  p_current  = p_neutral;
                  p_sweeping = 1'b0;
               end
               w.drive = 1'b1;
            end
         end
         CMD_START: begin
            if (!p_sweeping) begin
               p_start    = p_neutral;
               p_target   = clamp_pos(longint'(p_neutral) + longint'(ofs));
               p_elapsed  = '0;
               p_sweeping = 1'b1;
            end
         end
         CMD_RETURN: begin
            p_sweeping = 1'b0;
            p_current  = p_neutral;
            w.drive    = 1'b1;
         end
         default: ;
      endcase
      w.pos  = p_current;
      w.busy = p_sweeping;
      return w;
   endfunction

   task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
      if (errors < PRINT_CAP)
         $display("ERROR %0t: %s: expected %0d, got %0d", $time, what, want, got);
      errors++;
   endtask

   // driver: prediction is taken at the edge where the word is accepted
   always @(posedge clock) begin : drive_req
      servo_req_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            owed_words.push_back(advance_servo(req_if.cmd, req_if.offset_us));
         if (!req_if.valid || req_if.ready) begin
            if (req_words.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
                (!req_words[0].hold || owed_words.size() == 0)) begin
               nxt = req_words.pop_front();
               req_if.valid     <= 1'b1;
               req_if.cmd       <= nxt.cmd;
               req_if.offset_us <= nxt.offset;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_rsp
      servo_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_words.size() == 0) begin
               flag_mismatch("response word with none expected", 0, rsp_if.position_us);
            end else begin
               want = owed_words.pop_front();
               if (rsp_if.position_us !== want.pos)
                  flag_mismatch("position_us", want.pos, rsp_if.position_us);
               if (rsp_if.drive !== want.drive)
                  flag_mismatch("drive", want.drive, rsp_if.drive);
               if (rsp_if.busy_res !== want.busy)
                  flag_mismatch("busy_res", want.busy, rsp_if.busy_res);
            end
         end
         rsp_if.ready <= !holdoff_active && ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      holdoff_active = 1'b0;
      wait (holdoff_go);
      @(posedge clock);
      holdoff_active <= 1'b1;
      repeat (HOLDOFF_TICKS) @(posedge clock);
      holdoff_active <= 1'b0;
   end

   initial begin
      #20ms;
      $display("servo_triangle_sweep: mismatch");
      $finish;
   end

   task automatic push_word(logic [CMD_W-1:0] cmd, logic signed [OFFSET_W-1:0] ofs,
                            bit hold = 1'b0);
      servo_req_type r;
      r.cmd    = cmd;
      r.offset = ofs;
      r.hold   = hold || ($urandom_range(49) == 0);
      req_words.push_back(r);
   endtask

   function automatic logic signed [OFFSET_W-1:0] random_offset();
      case ($urandom_range(7))
         0: return OFS_MIN;
         1: return OFS_MAX;
         2: return '0;
         default: return OFFSET_W'($urandom_range(4095));
      endcase
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_NEUTRAL) p_neutral = data[POS_W-1:0];
      else p_duration = data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sampled on the falling edge so pending updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (req_words.size() != 0 || req_if.valid || owed_words.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random_phase(int idx);
      int made;
      int span_ticks;
      int cut;
      logic [CSR_DATA_W-1:0] data;
      made = 0;
      case (idx % 4)
         0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
         1: begin sender_idle_pct = 80; sink_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  sink_stall_pct = 80; end
         default: begin sender_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      // sometimes only one register changes, leaving a sweep running mid-change
      if ($urandom_range(3) != 0) begin
         case ($urandom_range(9))
            0: data = '0;
            1: data = CSR_DATA_W'(POS_TOP);
            2: data = CSR_DATA_W'($urandom_range(65535));   // junk above bit 11
            default: data = CSR_DATA_W'($urandom_range(2500, 500));
         endcase
         write_csr(CSR_NEUTRAL, data);
      end
      if ($urandom_range(3) != 0) begin
         case ($urandom_range(11))
            0: data = '0;
            1: data = '1;
            2: data = CSR_DATA_W'(1);
            3: data = CSR_DATA_W'($urandom_range(40, 13));
            default: data = CSR_DATA_W'($urandom_range(12, 2));
         endcase
         write_csr(CSR_DURATION, data);
      end
      if (idx == 4) holdoff_go = 1'b1;
      while (made < PHASE_WORDS) begin
         if ($urandom_range(99) < 80) begin
            if (p_duration == 0) span_ticks = 1;
            else if (p_duration > 40) span_ticks = $urandom_range(40, 5);
            else span_ticks = 2 * p_duration;
            cut = ($urandom_range(9) == 0);
            if (cut) span_ticks = $urandom_range(span_ticks, 0);
            push_word(CMD_START, random_offset());
            repeat (span_ticks) push_word(CMD_TICK, random_offset());
            if (cut || p_duration > 40) push_word(CMD_RETURN, random_offset());
            made += 1 + span_ticks + (cut || p_duration > 40);
         end else begin
            case ($urandom_range(3))
               0: push_word(CMD_UNUSED, random_offset());
               1: push_word(CMD_TICK, random_offset());
               2: push_word(CMD_RETURN, random_offset());
               default: push_word(CMD_START, random_offset());
            endcase
            made++;
         end
      end
      sweep_words_made += made;
      wait_drained();
   endtask

   initial begin
      int phase;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.cmd       = CMD_TICK;
      req_if.offset_us = '0;
      rsp_if.ready     = 1'b0;
      sender_idle_pct  = 0;
      sink_stall_pct   = 0;
      errors           = 0;
      sweep_words_made = 0;
      holdoff_go       = 1'b0;
      p_neutral        = NEUTRAL_RESET;
      p_duration       = DURATION_RESET;
      p_sweeping       = 1'b0;
      p_elapsed        = '0;
      p_target         = POS_RESET;
      p_start          = POS_RESET;
      p_current        = POS_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // power-on registers: idle commands, ignored start, clamp to zero
      push_word(CMD_TICK, OFS_MAX);
      push_word(CMD_UNUSED, OFS_MAX);
      push_word(CMD_RETURN, OFS_MIN);
      push_word(CMD_START, OFS_MAX);
      push_word(CMD_START, OFS_MIN);
      push_word(CMD_TICK, '0);
      push_word(CMD_TICK, OFS_MIN);
      push_word(CMD_UNUSED, OFS_MIN);
      push_word(CMD_RETURN, '0, 1'b1);
      push_word(CMD_START, OFS_MIN);
      push_word(CMD_TICK, '0);
      push_word(CMD_RETURN, '0);
      wait_drained();

      // top neutral, shortest nonzero duration, clamp to full scale
      write_csr(CSR_NEUTRAL, CSR_DATA_W'(POS_TOP));
      write_csr(CSR_DURATION, CSR_DATA_W'(1));
      push_word(CMD_START, OFS_MAX);
      repeat (3) push_word(CMD_TICK, '0);
      push_word(CMD_START, OFS_MIN);
      repeat (2) push_word(CMD_TICK, '0);
      wait_drained();

      // zero duration ends on the first tick
      write_csr(CSR_NEUTRAL, '0);
      write_csr(CSR_DURATION, '0);
      push_word(CMD_START, OFS_MIN);
      push_word(CMD_TICK, '0);
      push_word(CMD_START, OFS_MAX);
      push_word(CMD_TICK, '0);
      wait_drained();

      // longest duration; this sweep carries into the first random phase
      write_csr(CSR_NEUTRAL, CSR_DATA_W'(2000));
      write_csr(CSR_DURATION, '1);
      push_word(CMD_START, OFS_MIN);
      repeat (2) push_word(CMD_TICK, '0);
      wait_drained();

      phase = 0;
      while (sweep_words_made < RANDOM_WORDS) begin
         run_random_phase(phase);
         phase++;
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (owed_words.size() != 0)
         flag_mismatch("words never returned", 0, owed_words.size());
      if (errors == 0) begin
         $display("servo_triangle_sweep: match");
      end else begin
         $display("servo_triangle_sweep: mismatch");
      end
      $finish;
   end

endmodule
